// ----- rtl/nod_pkg.sv -----
// Shared types and constants for the nearest obstacle distance map.
// Field widths, register indexes, reset values and the sequencer state type.
// No dependencies.
package nod_pkg;

    // Field widths
    localparam int CELL_W     = 6;
    localparam int OCC_W      = 8;
    localparam int DIST_W     = 7;
    localparam int SIDE_CFG_W = 7;
    localparam int SCALE_W    = 4;
    localparam int SQ_W       = 2 * SCALE_W;

    // Stream and configuration port widths
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Default grid side
    localparam int GRID_SIDE_DEF = 64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAP         = 3'd4;

    // Register reset values
    localparam logic [SIDE_CFG_W-1:0] GRID_WIDTH_RST  = 7'd64;
    localparam logic [SIDE_CFG_W-1:0] GRID_HEIGHT_RST = 7'd64;
    localparam logic [OCC_W-1:0]      THRESHOLD_RST   = 8'd50;
    localparam logic [SCALE_W-1:0]    SCALE_RST       = 4'd5;
    localparam logic [DIST_W-1:0]     CAP_RST         = 7'd100;

    // Item kinds
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_ROOT,
        ST_FIN
    } nod_state_t;

endpackage

// ----- rtl/nearest_obstacle_distance_map.sv -----
// Nearest obstacle distance map: obstacle bitmap, scan sequencer and root unit.
// Depends on nod_pkg.
//
// After reset the block sweeps the obstacle bitmap clear, one cell a cycle, over all
// 4^ceil(log2(GRID_SIDE)) cells (4096 at the default side of 64); it takes no
// word in that time, though configuration writes are taken. A load word is then
// written to the bitmap in the cycle it is taken. A query word scans the grid in use
// one cell a cycle through a single read port of the bitmap; then come the pipeline
// drain and the multiply, the two-bit-a-step square root unit when an obstacle was
// found, and the hand-over of the answer to the output register, which waits while
// that register still holds an answer not yet taken. A query outside the grid skips
// the scan, drain, multiply and root. The input is not ready while a query is in
// progress; the output register lets the next word be taken while an answer still
// waits.
module nearest_obstacle_distance_map
    import nod_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [5:0] cell_x, [11:6] cell_y,
                                                  // [19:12] occupancy, rest zero
    input  logic                  s_axis_tuser,   // [0] func
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [6:0] distance, [7] zero
    output logic                  m_axis_tuser,   // [0] valid_res
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Derived widths
    localparam int XW    = $clog2(GRID_SIDE);
    localparam int AW    = 2 * XW;
    localparam int WW    = $clog2(GRID_SIDE + 1);
    localparam int CLW   = (WW > SIDE_CFG_W) ? WW : SIDE_CFG_W;
    localparam int CW    = (XW > CELL_W) ? XW : CELL_W;
    localparam int D2W   = 2 * XW + 1;
    localparam int PW    = D2W + SQ_W;
    localparam int RW    = (PW + 1) / 2;
    localparam int NW    = 2 * RW;
    localparam int CNTW  = $clog2(RW + 1);
    localparam int CMW   = (RW > DIST_W) ? RW : DIST_W;
    localparam int DEPTH = 1 << AW;

    // Input fields
    logic [CELL_W-1:0]       in_cell_x;
    logic [CELL_W-1:0]       in_cell_y;
    logic signed [OCC_W-1:0] in_occupancy;
    logic                    in_func;

    assign in_cell_x    = s_axis_tdata[CELL_W-1:0];
    assign in_cell_y    = s_axis_tdata[2*CELL_W-1:CELL_W];
    assign in_occupancy = s_axis_tdata[2*CELL_W+OCC_W-1:2*CELL_W];
    assign in_func      = s_axis_tuser;

    // Configuration registers
    logic [SIDE_CFG_W-1:0]   gw_reg;
    logic [SIDE_CFG_W-1:0]   gh_reg;
    logic signed [OCC_W-1:0] thr_reg;
    logic [SCALE_W-1:0]      scale_reg;
    logic [DIST_W-1:0]       cap_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg    <= GRID_WIDTH_RST;
            gh_reg    <= GRID_HEIGHT_RST;
            thr_reg   <= THRESHOLD_RST;
            scale_reg <= SCALE_RST;
            cap_reg   <= CAP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  gw_reg    <= cfg_data[SIDE_CFG_W-1:0];
                REG_GRID_HEIGHT: gh_reg    <= cfg_data[SIDE_CFG_W-1:0];
                REG_THRESHOLD:   thr_reg   <= cfg_data[OCC_W-1:0];
                REG_SCALE:       scale_reg <= cfg_data[SCALE_W-1:0];
                REG_CAP:         cap_reg   <= cfg_data[DIST_W-1:0];
                default:         ;
            endcase
        end
    end

    // Grid in use, clipped to the stored side
    logic [CLW-1:0] side_c;
    logic [CLW-1:0] gw_c;
    logic [CLW-1:0] gh_c;
    logic [CLW-1:0] w_use;
    logic [CLW-1:0] h_use;
    logic           in_inside;
    logic [CW-1:0]  cx_w;
    logic [CW-1:0]  cy_w;
    logic [XW-1:0]  in_x;
    logic [XW-1:0]  in_y;

    assign side_c    = CLW'(GRID_SIDE);
    assign gw_c      = CLW'(gw_reg);
    assign gh_c      = CLW'(gh_reg);
    assign w_use     = (gw_c > side_c) ? side_c : gw_c;
    assign h_use     = (gh_c > side_c) ? side_c : gh_c;
    assign in_inside = (CLW'(in_cell_x) < w_use) && (CLW'(in_cell_y) < h_use);
    assign cx_w      = CW'(in_cell_x);
    assign cy_w      = CW'(in_cell_y);
    assign in_x      = cx_w[XW-1:0];
    assign in_y      = cy_w[XW-1:0];

    // Sequencer and datapath registers
    nod_state_t      state_reg, state_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [XW-1:0]   x_reg, x_next;
    logic [XW-1:0]   y_reg, y_next;
    logic [XW-1:0]   qx_reg, qx_next;
    logic [XW-1:0]   qy_reg, qy_next;
    logic            inside_reg, inside_next;
    logic [SQ_W-1:0] s2_reg, s2_next;
    logic            a_valid_reg, a_valid_next;
    logic            a_last_reg, a_last_next;
    logic [XW-1:0]   a_x_reg, a_x_next;
    logic [XW-1:0]   a_y_reg, a_y_next;
    logic            b_hit_reg, b_hit_next;
    logic            b_last_reg, b_last_next;
    logic [AW-1:0]   dx2_reg, dx2_next;
    logic [AW-1:0]   dy2_reg, dy2_next;
    logic [D2W-1:0]  best_reg, best_next;
    logic            found_reg, found_next;
    logic [NW-1:0]   n_reg, n_next;
    logic [RW+1:0]   rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            m_valid_reg, m_valid_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic            vres_reg, vres_next;

    // Bitmap port signals
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic            mem_wd;
    logic [AW-1:0]   mem_ra;
    logic            rd_reg;

    // Obstacle bitmap: one write port, one registered read port
    logic bitmap_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= bitmap_mem[mem_ra];
    end

    assign mem_ra = {y_reg, x_reg};

    // Scan datapath helpers
    logic [XW-1:0]  dx;
    logic [XW-1:0]  dy;
    logic [AW-1:0]  dx_w;
    logic [AW-1:0]  dy_w;
    logic [D2W-1:0] d2;
    logic           issue_last;
    logic [PW-1:0]  prod;
    logic [RW+1:0]  rem_sh;
    logic [RW+1:0]  trial;
    logic [CMW-1:0] root_e;
    logic [CMW-1:0] cap_e;
    logic [DIST_W-1:0] root_capped;
    logic           s_acc;
    logic           out_free;

    assign dx   = (a_x_reg > qx_reg) ? (a_x_reg - qx_reg) : (qx_reg - a_x_reg);
    assign dy   = (a_y_reg > qy_reg) ? (a_y_reg - qy_reg) : (qy_reg - a_y_reg);
    assign dx_w = AW'(dx);
    assign dy_w = AW'(dy);
    assign d2   = D2W'(dx2_reg) + D2W'(dy2_reg);

    assign issue_last = (CLW'(x_reg) == w_use - CLW'(1)) && (CLW'(y_reg) == h_use - CLW'(1));

    assign prod   = PW'(best_reg) * PW'(s2_reg);
    assign rem_sh = {rem_reg[RW-1:0], n_reg[NW-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    assign root_e      = CMW'(root_reg);
    assign cap_e       = CMW'(cap_reg);
    assign root_capped = (root_e > cap_e) ? cap_reg : root_e[DIST_W-1:0];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Next state, datapath and bitmap port
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        qx_next       = qx_reg;
        qy_next       = qy_reg;
        inside_next   = inside_reg;
        s2_next       = s2_reg;
        best_next     = best_reg;
        found_next    = found_reg;
        n_next        = n_reg;
        rem_next      = rem_reg;
        root_next     = root_reg;
        cnt_next      = cnt_reg;
        dist_next     = dist_reg;
        vres_next     = vres_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;

        // scan pipeline: read, square, compare
        a_valid_next = 1'b0;
        a_last_next  = 1'b0;
        a_x_next     = x_reg;
        a_y_next     = y_reg;
        b_hit_next   = a_valid_reg && rd_reg;
        b_last_next  = a_last_reg;
        dx2_next     = dx_w * dx_w;
        dy2_next     = dy_w * dy_w;

        if (b_hit_reg && (!found_reg || d2 < best_reg))
        begin
            best_next  = d2;
            found_next = 1'b1;
        end

        mem_we = 1'b0;
        mem_wa = {in_y, in_x};
        mem_wd = (in_occupancy > thr_reg);

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_wa        = clr_addr_reg;
                mem_wd        = 1'b0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == {AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (s_acc)
                begin
                    if (in_func == FUNC_LOAD)
                    begin
                        mem_we = in_inside;
                    end
                    else
                    begin
                        qx_next     = in_x;
                        qy_next     = in_y;
                        inside_next = in_inside;
                        s2_next     = SQ_W'(scale_reg) * SQ_W'(scale_reg);
                        found_next  = 1'b0;
                        x_next      = '0;
                        y_next      = '0;
                        state_next  = in_inside ? ST_SCAN : ST_FIN;
                    end
                end
            end

            ST_SCAN:
            begin
                a_valid_next = 1'b1;
                a_last_next  = issue_last;
                if (CLW'(x_reg) == w_use - CLW'(1))
                begin
                    x_next = '0;
                    y_next = y_reg + XW'(1);
                end
                else
                begin
                    x_next = x_reg + XW'(1);
                end
                if (issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                if (b_last_reg)
                begin
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                n_next     = NW'(prod);
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = CNTW'(RW);
                state_next = found_reg ? ST_ROOT : ST_FIN;
            end

            ST_ROOT:
            begin
                // two bits of the radicand a step
                n_next   = {n_reg[NW-3:0], 2'b00};
                cnt_next = cnt_reg - CNTW'(1);
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[RW-2:0], 1'b0};
                end
                if (cnt_reg == CNTW'(1))
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    vres_next    = inside_reg;
                    if (!inside_reg)
                    begin
                        dist_next = '0;
                    end
                    else if (found_reg)
                    begin
                        dist_next = root_capped;
                    end
                    else
                    begin
                        dist_next = cap_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            a_valid_reg  <= 1'b0;
            a_last_reg   <= 1'b0;
            b_hit_reg    <= 1'b0;
            b_last_reg   <= 1'b0;
            found_reg    <= 1'b0;
            inside_reg   <= 1'b0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            a_valid_reg  <= a_valid_next;
            a_last_reg   <= a_last_next;
            b_hit_reg    <= b_hit_next;
            b_last_reg   <= b_last_next;
            found_reg    <= found_next;
            inside_reg   <= inside_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        s2_reg   <= s2_next;
        a_x_reg  <= a_x_next;
        a_y_reg  <= a_y_next;
        dx2_reg  <= dx2_next;
        dy2_reg  <= dy2_next;
        best_reg <= best_next;
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        dist_reg <= dist_next;
        vres_reg <= vres_next;
    end

    // Output word
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(dist_reg);
    assign m_axis_tuser  = vres_reg;

endmodule

// ----- verif/tb_nearest_obstacle_distance_map.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for nearest_obstacle_distance_map: load and query words are
// streamed in, answers are predicted from a local copy of the obstacle map and compared.
// Depends on nod_pkg and nearest_obstacle_distance_map.
module tb_nearest_obstacle_distance_map;
    import nod_pkg::*;

    localparam int SIDE         = GRID_SIDE_DEF;
    localparam int PAUSE_CYCLES = 16;
    localparam int END_CYCLES   = 64;

    typedef struct packed {
        logic              func;
        logic [CELL_W-1:0] x;
        logic [CELL_W-1:0] y;
        logic [OCC_W-1:0]  occ;
    } cell_word_t;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              in_grid;
    } answer_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = FUNC_LOAD;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = REG_GRID_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // Predictor state: settings and obstacle map as the block should hold them
    logic [SIDE_CFG_W-1:0] map_width     = GRID_WIDTH_RST;
    logic [SIDE_CFG_W-1:0] map_height    = GRID_HEIGHT_RST;
    logic signed [OCC_W-1:0] map_threshold = THRESHOLD_RST;
    logic [SCALE_W-1:0]    map_scale     = SCALE_RST;
    logic [DIST_W-1:0]     map_cap       = CAP_RST;
    bit                    obstacle_map [SIDE*SIDE];

    cell_word_t word_q [$];
    answer_t    answer_q [$];
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         errors         = 0;

    nearest_obstacle_distance_map dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // Grid side in use, clipped to the stored map
    function automatic int clipped(logic [SIDE_CFG_W-1:0] v);
        return (int'(v) > SIDE) ? SIDE : int'(v);
    endfunction

    // Scaled, capped distance from a cell to the nearest obstacle in the grid in use
    function automatic answer_t nearest_distance(int cx, int cy);
        answer_t a;
        int      w, h, best, d2, dx, dy, s, n, r;
        w          = clipped(map_width);
        h          = clipped(map_height);
        a.distance = '0;
        a.in_grid  = 1'b0;
        if (cx >= w || cy >= h)
            return a;
        best = -1;
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                if (obstacle_map[y*SIDE + x])
                begin
                    dx = x - cx;
                    dy = y - cy;
                    d2 = dx*dx + dy*dy;
                    if (best < 0 || d2 < best)
                        best = d2;
                end
            end
        end
        a.in_grid = 1'b1;
        if (best < 0)
            a.distance = map_cap;
        else
        begin
            s = int'(map_scale);
            n = s*s*best;
            // integer root, stopping at the cap
            r = 0;
            while (r < int'(map_cap) && (r+1)*(r+1) <= n)
                r++;
            a.distance = DIST_W'(r);
        end
        return a;
    endfunction

    // Apply an accepted word to the map, or queue the answer it must produce
    function automatic void track_word(cell_word_t wd);
        int w, h;
        w = clipped(map_width);
        h = clipped(map_height);
        if (wd.func == FUNC_LOAD)
        begin
            if (int'(wd.x) < w && int'(wd.y) < h)
                obstacle_map[int'(wd.y)*SIDE + int'(wd.x)] = ($signed(wd.occ) > map_threshold);
        end
        else
            answer_q = {answer_q, nearest_distance(int'(wd.x), int'(wd.y))};
    endfunction

    task automatic queue_word(logic func, int x, int y, int occ);
        cell_word_t wd;
        wd.func = func;
        wd.x    = CELL_W'(x);
        wd.y    = CELL_W'(y);
        wd.occ  = OCC_W'(occ);
        word_q  = {word_q, wd};
    endtask

    // Random word: mostly cells inside the grid, occupancy near the threshold in a quarter of the words
    task automatic queue_random_word();
        int   w, h, x, y, occ;
        logic func;
        w    = clipped(map_width);
        h    = clipped(map_height);
        func = ($urandom_range(99) < 40) ? FUNC_QUERY : FUNC_LOAD;
        if ($urandom_range(99) < 88 && w > 0 && h > 0)
        begin
            x = $urandom_range(w-1);
            y = $urandom_range(h-1);
        end
        else
        begin
            x = $urandom_range(SIDE-1);
            y = $urandom_range(SIDE-1);
        end
        case ($urandom_range(3))
            0: occ = int'(map_threshold) + $urandom_range(4) - 2;
            1: occ = $urandom_range(101) - 1;
            2: occ = $urandom_range(255);
            default: occ = -1;
        endcase
        queue_word(func, x, y, occ);
    endtask

    // One register write over the configuration channel
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GRID_WIDTH:  map_width     = val[SIDE_CFG_W-1:0];
            REG_GRID_HEIGHT: map_height    = val[SIDE_CFG_W-1:0];
            REG_THRESHOLD:   map_threshold = val;
            REG_SCALE:       map_scale     = val[SCALE_W-1:0];
            REG_CAP:         map_cap       = val[DIST_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int w, int h, int thr, int scale, int cap);
        write_reg(REG_GRID_WIDTH,  CFG_DATA_W'(w));
        write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_THRESHOLD,   CFG_DATA_W'(thr));
        write_reg(REG_SCALE,       CFG_DATA_W'(scale));
        write_reg(REG_CAP,         CFG_DATA_W'(cap));
    endtask

    // Wait until every word is taken and every answer is back, then let loads settle
    task automatic drain_stream(int settle);
        while (word_q.size() != 0 || s_axis_tvalid || answer_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
        @(negedge clk);
    endtask

    // Input driver: holds a word until taken, then offers the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= FUNC_LOAD;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                track_word(word_q.pop_front());
            if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {4'b0, word_q[0].occ, word_q[0].y, word_q[0].x};
                s_axis_tuser  <= word_q[0].func;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Output back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Answer checker
    always @(posedge clk)
    begin : answer_check
        answer_t want;
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            if (answer_q.size() == 0)
            begin
                $display("%0t: unexpected answer, got tdata %h tuser %b",
                         $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                want = answer_q.pop_front();
                if (m_axis_tdata !== {1'b0, want.distance})
                begin
                    $display("%0t: distance mismatch, expected %h, got %h",
                             $time, {1'b0, want.distance}, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== want.in_grid)
                begin
                    $display("%0t: valid_res mismatch, expected %b, got %b",
                             $time, want.in_grid, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int w, h, thr;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: empty map, then one far obstacle and a load at the threshold that stays clear
        queue_word(FUNC_QUERY, 0, 0, 0);
        queue_word(FUNC_LOAD, 63, 63, 51);
        queue_word(FUNC_LOAD, 0, 0, 50);
        queue_word(FUNC_QUERY, 0, 0, 0);
        queue_word(FUNC_QUERY, 63, 62, -128);
        queue_word(FUNC_QUERY, 63, 63, 127);
        drain_stream(PAUSE_CYCLES);

        // Small grid, lowest sensible threshold, largest scale and cap
        set_config(8, 4, -1, 15, 127);
        @(negedge clk);
        queue_word(FUNC_LOAD, 2, 1, 0);
        queue_word(FUNC_LOAD, 7, 3, -1);
        queue_word(FUNC_LOAD, 8, 0, 100);
        queue_word(FUNC_LOAD, 0, 4, 127);
        queue_word(FUNC_QUERY, 0, 0, 0);
        queue_word(FUNC_QUERY, 8, 0, 0);
        queue_word(FUNC_QUERY, 7, 3, 0);
        queue_word(FUNC_QUERY, 2, 1, 0);
        queue_word(FUNC_QUERY, 5, 63, 0);
        drain_stream(PAUSE_CYCLES);

        // Scale zero
        set_config(8, 4, -1, 0, 127);
        @(negedge clk);
        queue_word(FUNC_QUERY, 5, 3, 0);
        drain_stream(PAUSE_CYCLES);

        // Empty grid: loads ignored, queries out of range
        set_config(0, 4, -128, 15, 127);
        @(negedge clk);
        queue_word(FUNC_LOAD, 0, 0, -127);
        queue_word(FUNC_QUERY, 0, 0, 0);
        drain_stream(PAUSE_CYCLES);

        // Oversized settings clip to the full map; earlier obstacles come back into view
        set_config(127, 100, -128, 1, 127);
        @(negedge clk);
        queue_word(FUNC_LOAD, 10, 10, -128);
        queue_word(FUNC_LOAD, 20, 20, -127);
        queue_word(FUNC_QUERY, 62, 0, 0);
        drain_stream(PAUSE_CYCLES);

        // Highest threshold and zero cap
        set_config(4, 4, 127, 15, 0);
        @(negedge clk);
        queue_word(FUNC_LOAD, 1, 1, 127);
        queue_word(FUNC_QUERY, 0, 0, 0);
        drain_stream(PAUSE_CYCLES);

        // Random part: four idling phases, two settings each, one on a large grid
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            for (int k = 0; k < 2; k++)
            begin
                if (ph == 1 && k == 1)
                begin
                    w = ($urandom_range(1) == 0) ? SIDE : $urandom_range(127, SIDE);
                    h = $urandom_range(SIDE, 40);
                end
                else
                begin
                    w = $urandom_range(12, 1);
                    h = $urandom_range(12, 1);
                end
                thr = ($urandom_range(99) < 80) ? $urandom_range(101) - 1
                                                : $urandom_range(255);
                set_config(w, h, thr, $urandom_range(15), $urandom_range(127));
                @(negedge clk);
                repeat (14) queue_random_word();
                drain_stream(PAUSE_CYCLES);
            end
        end

        drain_stream(END_CYCLES);
        if (errors == 0 && answer_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
